// ===== hw/rtl/uxt_pkg.sv =====
`default_nettype none

package uxt_pkg;

    localparam logic [1:0] ST_BYTE       = 2'd0;
    localparam logic [1:0] ST_INVALID    = 2'd1;
    localparam logic [1:0] ST_INCOMPLETE = 2'd2;
    localparam logic [1:0] ST_END        = 2'd3;

    localparam logic REG_SOURCE = 1'b0;
    localparam logic REG_TARGET = 1'b1;

    localparam logic [31:0] MAX_SCALAR = 32'h0010_FFFF;
    localparam logic [15:0] HIGH_FIRST = 16'hD800;
    localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
    localparam logic [15:0] LOW_FIRST  = 16'hDC00;
    localparam logic [15:0] LOW_LAST   = 16'hDFFF;
    localparam logic [20:0] PLANE_BASE = 21'h01_0000;

    typedef struct packed {
        logic [1:0]  status;
        logic [20:0] scalar;
        logic [1:0]  target;
    } job_t;

endpackage

`default_nettype wire

// ===== hw/rtl/uxt_front.sv =====
`default_nettype none

module uxt_front
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic [7:0]    data_byte,
    input  wire logic          is_end,
    input  wire logic          cfg_we,
    input  wire logic          cfg_index,
    input  wire logic [1:0]    cfg_data,
    output      logic          job_valid,
    output      uxt_pkg::job_t job
);

    logic [1:0]  src_reg;
    logic [1:0]  tgt_reg;
    logic [31:0] acc_reg;
    logic [31:0] acc_next;
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    logic        pend_reg;
    logic        pend_next;
    logic        halt_reg;
    logic        halt_next;

    logic        size4;
    logic [1:0]  last_idx;
    logic [1:0]  pos;
    logic [31:0] base;
    logic [31:0] acc_new;
    logic [15:0] hi;
    logic [15:0] w16;
    logic        hi_is_high;
    logic        w_is_high;
    logic        w_is_low;

    assign size4    = src_reg[1];
    assign last_idx = size4 ? 2'd3 : 2'd1;
    assign pos      = src_reg[0] ? (last_idx - cnt_reg) : cnt_reg;
    assign base     = (cnt_reg != 2'd0) ? acc_reg :
                      (size4 ? 32'd0 : {acc_reg[31:16], 16'd0});
    assign acc_new  = base | ({24'd0, data_byte} << {pos, 3'b000});
    assign hi       = acc_reg[31:16];
    assign w16      = acc_new[15:0];
    assign hi_is_high = (hi >= uxt_pkg::HIGH_FIRST) && (hi <= uxt_pkg::HIGH_LAST);
    assign w_is_high  = (w16 >= uxt_pkg::HIGH_FIRST) && (w16 <= uxt_pkg::HIGH_LAST);
    assign w_is_low   = (w16 >= uxt_pkg::LOW_FIRST) && (w16 <= uxt_pkg::LOW_LAST);

    always_comb
    begin
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        pend_next  = pend_reg;
        halt_next  = halt_reg;
        job_valid  = 1'b0;
        job.status = uxt_pkg::ST_BYTE;
        job.scalar = acc_new[20:0];
        job.target = tgt_reg;
        if (accept)
        begin
            if (is_end)
            begin
                job_valid  = 1'b1;
                job.status = (!halt_reg && (cnt_reg != 2'd0 || pend_reg)) ?
                             uxt_pkg::ST_INCOMPLETE : uxt_pkg::ST_END;
                acc_next   = 32'd0;
                cnt_next   = 2'd0;
                pend_next  = 1'b0;
                halt_next  = 1'b0;
            end
            else if (!halt_reg)
            begin
                acc_next = acc_new;
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == last_idx)
                begin
                    cnt_next = 2'd0;
                    if (size4)
                    begin
                        acc_next  = 32'd0;
                        job_valid = 1'b1;
                        if ((acc_new > uxt_pkg::MAX_SCALAR) ||
                            ((acc_new >= {16'd0, uxt_pkg::HIGH_FIRST}) &&
                             (acc_new <= {16'd0, uxt_pkg::LOW_LAST})))
                        begin
                            job.status = uxt_pkg::ST_INVALID;
                            halt_next  = 1'b1;
                            pend_next  = 1'b0;
                        end
                    end
                    else if (pend_reg)
                    begin
                        acc_next  = 32'd0;
                        pend_next = 1'b0;
                        job_valid = 1'b1;
                        if (!w_is_low || !hi_is_high)
                        begin
                            job.status = uxt_pkg::ST_INVALID;
                            halt_next  = 1'b1;
                        end
                        else
                        begin
                            job.scalar = 21'({hi[9:0], w16[9:0]}) + uxt_pkg::PLANE_BASE;
                        end
                    end
                    else if (w_is_high)
                    begin
                        pend_next = 1'b1;
                        acc_next  = {w16, 16'd0};
                    end
                    else
                    begin
                        acc_next   = 32'd0;
                        job_valid  = 1'b1;
                        job.scalar = {5'd0, w16};
                        if (w_is_low)
                        begin
                            job.status = uxt_pkg::ST_INVALID;
                            halt_next  = 1'b1;
                        end
                    end
                end
            end
        end
        if (cfg_we && cfg_index == uxt_pkg::REG_SOURCE)
        begin
            acc_next  = 32'd0;
            cnt_next  = 2'd0;
            pend_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg  <= 2'd0;
            tgt_reg  <= 2'd0;
            acc_reg  <= 32'd0;
            cnt_reg  <= 2'd0;
            pend_reg <= 1'b0;
            halt_reg <= 1'b0;
        end
        else
        begin
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
            pend_reg <= pend_next;
            halt_reg <= halt_next;
            if (cfg_we && cfg_index == uxt_pkg::REG_SOURCE)
            begin
                src_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == uxt_pkg::REG_TARGET)
            begin
                tgt_reg <= cfg_data;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/uxt_job_fifo.sv =====
`default_nettype none

module uxt_job_fifo
#(
    parameter int unsigned DEPTH = 2
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire uxt_pkg::job_t wr_job,
    input  wire logic          rd_en,
    output      uxt_pkg::job_t rd_job,
    output      logic          fifo_full,
    output      logic          fifo_empty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    uxt_pkg::job_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] cnt_reg;
    logic          do_wr;
    logic          do_rd;

    assign fifo_full  = (cnt_reg == FULL_CNT);
    assign fifo_empty = (cnt_reg == '0);
    assign do_wr      = wr_en && !fifo_full;
    assign do_rd      = rd_en && !fifo_empty;
    assign rd_job     = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/uxt_back.sv =====
`default_nettype none

module uxt_back
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire uxt_pkg::job_t job,
    input  wire logic          job_empty,
    output      logic          job_pop,
    input  wire logic          pop,
    output      logic          empty,
    output      logic [7:0]    out_byte,
    output      logic [1:0]    status,
    output      logic          last
);

    logic        cur_valid_reg;
    logic [31:0] word_reg;
    logic [1:0]  idx_reg;
    logic [1:0]  nlast_reg;
    logic [1:0]  stat_reg;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic [1:0]  out_stat_reg;
    logic        out_last_reg;

    logic        emit;
    logic        cur_done;
    logic        load;
    logic [31:0] word_next;
    logic [1:0]  nlast_next;
    logic [31:0] sel_word;

    function automatic logic [15:0] unit_bytes(input logic [15:0] u, input logic be);
        unit_bytes = be ? {u[7:0], u[15:8]} : u;
    endfunction

    always_comb
    begin
        logic [19:0] v;
        logic [15:0] hs;
        logic [15:0] ls;
        v          = 20'(job.scalar - uxt_pkg::PLANE_BASE);
        hs         = uxt_pkg::HIGH_FIRST + {6'd0, v[19:10]};
        ls         = uxt_pkg::LOW_FIRST + {6'd0, v[9:0]};
        word_next  = 32'd0;
        nlast_next = 2'd0;
        if (job.status == uxt_pkg::ST_BYTE)
        begin
            if (job.target[1])
            begin
                nlast_next = 2'd3;
                word_next  = job.target[0] ?
                             {job.scalar[7:0], job.scalar[15:8], 3'd0, job.scalar[20:16],
                              8'd0} : {11'd0, job.scalar};
            end
            else if (job.scalar >= uxt_pkg::PLANE_BASE)
            begin
                nlast_next = 2'd3;
                word_next  = {unit_bytes(ls, job.target[0]), unit_bytes(hs, job.target[0])};
            end
            else
            begin
                nlast_next = 2'd1;
                word_next  = {16'd0, unit_bytes(job.scalar[15:0], job.target[0])};
            end
        end
    end

    assign emit     = cur_valid_reg && (!out_valid_reg || pop);
    assign cur_done = emit && (idx_reg == nlast_reg);
    assign load     = !job_empty && (!cur_valid_reg || cur_done);
    assign job_pop  = load;
    assign sel_word = word_reg >> {idx_reg, 3'b000};

    assign empty    = !out_valid_reg;
    assign out_byte = out_byte_reg;
    assign status   = out_stat_reg;
    assign last     = out_last_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg  <= word_next;
            nlast_reg <= nlast_next;
            stat_reg  <= job.status;
        end
        if (emit)
        begin
            out_byte_reg <= sel_word[7:0];
            out_stat_reg <= stat_reg;
            out_last_reg <= (idx_reg == nlast_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= 2'd0;
            end
            else
            begin
                if (cur_done)
                begin
                    cur_valid_reg <= 1'b0;
                end
                if (emit)
                begin
                    idx_reg <= idx_reg + 2'd1;
                end
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/utf16_utf32_byte_transcoder_unit.sv =====
// A byte that completes a character, or an end marker, is written to the job queue, loaded
// into the back end's word register, then held in the output register as its first result.
// Throughput: one input transaction per cycle until the job queue fills; the back end sends
// one result byte per cycle while the output is popped, and a character gives two or four bytes.
// Reset clears the assembly state, the job queue and the output register, and sets both
// encodings to UTF-16LE.
`default_nettype none

module utf16_utf32_byte_transcoder_unit
#(
    parameter int unsigned JOB_DEPTH = 2
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output      logic       full,
    input  wire logic [7:0] data_byte,
    input  wire logic       is_end,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [1:0] cfg_data,
    output      logic       empty,
    input  wire logic       pop,
    output      logic [7:0] out_byte,
    output      logic [1:0] status,
    output      logic       last
);

    logic          accept;
    logic          job_valid;
    uxt_pkg::job_t front_job;
    uxt_pkg::job_t back_job;
    logic          job_pop;
    logic          fifo_full;
    logic          fifo_empty;

    assign full   = fifo_full;
    assign accept = push && !fifo_full;

    uxt_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .is_end    (is_end),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .job_valid (job_valid),
        .job       (front_job)
    );

    uxt_job_fifo #(.DEPTH(JOB_DEPTH)) u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (job_valid),
        .wr_job     (front_job),
        .rd_en      (job_pop),
        .rd_job     (back_job),
        .fifo_full  (fifo_full),
        .fifo_empty (fifo_empty)
    );

    uxt_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (back_job),
        .job_empty (fifo_empty),
        .job_pop   (job_pop),
        .pop       (pop),
        .empty     (empty),
        .out_byte  (out_byte),
        .status    (status),
        .last      (last)
    );

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid |-> !fifo_full)
        else $error("job written into a full queue");

    a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != uxt_pkg::ST_BYTE) |-> last)
        else $error("status transaction not marked last");

    a_status_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != uxt_pkg::ST_BYTE) |-> (out_byte == 8'd0))
        else $error("status transaction carries a byte");

    a_end_gives_job: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_end) |-> job_valid)
        else $error("end marker produced no job");
`endif

endmodule

`default_nettype wire
